### src/pn3o_pkg.sv
// ----------------------------------------------------------------------------
// pn3o_pkg
// Shared types, constants and helper functions for the octave noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package pn3o_pkg;

  // Fixed widths of the fixed-point datapath
  localparam int unsigned CELL_W      = 8;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned FADE_W      = 17;
  localparam int unsigned GRAD_W      = 19;
  localparam int unsigned VAL_W       = 20;
  localparam int unsigned STEP_W      = 5;
  localparam int unsigned TABLE_DEPTH = 256;

  // Octave schedule: split, fade, hash chain, gradients, lerps, accumulate
  localparam logic [STEP_W-1:0] STEP_SPLIT = 5'd0;
  localparam logic [STEP_W-1:0] STEP_SQR   = 5'd1;
  localparam logic [STEP_W-1:0] STEP_CUBE  = 5'd2;
  localparam logic [STEP_W-1:0] STEP_FADE  = 5'd3;
  localparam logic [STEP_W-1:0] STEP_GRAD0 = 5'd8;
  localparam logic [STEP_W-1:0] STEP_LERP0 = 5'd16;
  localparam logic [STEP_W-1:0] STEP_LAST  = 5'd30;

  // Fade polynomial constants (ten in Q16, fifteen as a plain integer)
  localparam logic [20:0] FADE_TEN = 21'd655360;
  localparam logic [20:0] FADE_15  = 21'd15;

  // Output saturation limits (Q2.14)
  localparam logic [15:0] SAT_POS = 16'h7FFF;
  localparam logic [15:0] SAT_NEG = 16'h8000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FREQ = 2'd0,
    CFG_OCT  = 2'd1,
    CFG_AMP  = 2'd2
  } cfg_idx_e;

  // Commands from the controller to the datapath
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EVAL,
    CMD_ZERO,
    CMD_STEP,
    CMD_DIV_INIT,
    CMD_DIV,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [STEP_W-1:0] step;
  } ctrl_cmd_t;

  // Lerp j reads corners a and b and writes its result back over a
  function automatic logic [2:0] lerp_a(input logic [2:0] j);
    logic [2:0] r;
    case (j)
      3'd0:    r = 3'd0;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd4;
      3'd3:    r = 3'd6;
      3'd4:    r = 3'd0;
      3'd5:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lerp_b(input logic [2:0] j);
    logic [2:0] r;
    case (j)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd3;
      3'd2:    r = 3'd5;
      3'd3:    r = 3'd7;
      3'd4:    r = 3'd2;
      3'd5:    r = 3'd6;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  // Gradient select on the cube edge directions, offsets in Q16
  function automatic logic signed [GRAD_W-1:0] grad(
    input logic [3:0]         h,
    input logic signed [17:0] x,
    input logic signed [17:0] y,
    input logic signed [17:0] z
  );
    logic signed [17:0]       u;
    logic signed [17:0]       v;
    logic signed [GRAD_W-1:0] su;
    logic signed [GRAD_W-1:0] sv;
    u  = (h < 4'd8) ? x : y;
    v  = (h < 4'd4) ? y : (((h == 4'd12) || (h == 4'd14)) ? x : z);
    su = h[0] ? -{u[17], u} : {u[17], u};
    sv = h[1] ? -{v[17], v} : {v[17], v};
    return su + sv;
  endfunction

endpackage

`default_nettype wire

### src/pn3o_ctrl.sv
// ----------------------------------------------------------------------------
// pn3o_ctrl
// Sequencer: input and output handshakes, octave and step counters, divider
// step count. Drives one command per cycle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pn3o_ctrl #(
  parameter int unsigned MAX_OCTAVES = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 op_i,
  input  wire logic [3:0]           octave_count_i,
  input  wire logic                 amp_zero_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pn3o_pkg::ctrl_cmd_t       cmd_o
);

  localparam int unsigned TW = pn3o_pkg::VAL_W + MAX_OCTAVES;
  localparam int unsigned OW = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned DW = $clog2(TW + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_OCT  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e                           state_q, state_d;
  logic [pn3o_pkg::STEP_W-1:0]      step_q, step_d;
  logic [OW-1:0]                    oct_q, oct_d;
  logic [OW-1:0]                    cnt_q, cnt_d;
  logic [DW-1:0]                    div_q, div_d;
  logic                             out_valid_q, out_valid_d;
  logic [OW-1:0]                    cnt_sat;
  logic                             in_fire;

  // Octave count clamps to the built-in maximum
  assign cnt_sat = (32'(octave_count_i) > MAX_OCTAVES) ? OW'(MAX_OCTAVES)
                                                       : OW'(octave_count_i);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Next state and command
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    oct_d       = oct_q;
    cnt_d       = cnt_q;
    div_d       = div_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.cmd   = pn3o_pkg::CMD_NONE;
    cmd_o.step  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!op_i) begin
            cmd_o.cmd = pn3o_pkg::CMD_LOAD;
          end else if ((octave_count_i == 4'd0) || amp_zero_i) begin
            cmd_o.cmd = pn3o_pkg::CMD_ZERO;
            state_d   = ST_FIN;
          end else begin
            cmd_o.cmd = pn3o_pkg::CMD_EVAL;
            state_d   = ST_OCT;
            step_d    = pn3o_pkg::STEP_SPLIT;
            oct_d     = '0;
            cnt_d     = cnt_sat;
          end
        end
      end
      ST_OCT: begin
        cmd_o.cmd = pn3o_pkg::CMD_STEP;
        if (step_q == pn3o_pkg::STEP_LAST) begin
          step_d = pn3o_pkg::STEP_SPLIT;
          if (oct_q == cnt_q - OW'(1)) begin
            state_d = ST_PREP;
          end else begin
            oct_d = oct_q + OW'(1);
          end
        end else begin
          step_d = step_q + pn3o_pkg::STEP_W'(1);
        end
      end
      ST_PREP: begin
        cmd_o.cmd = pn3o_pkg::CMD_DIV_INIT;
        div_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.cmd = pn3o_pkg::CMD_DIV;
        div_d     = div_q + DW'(1);
        if (div_q == DW'(TW - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Result register is free or being emptied this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.cmd   = pn3o_pkg::CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      oct_q       <= '0;
      cnt_q       <= '0;
      div_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      oct_q       <= oct_d;
      cnt_q       <= cnt_d;
      div_q       <= div_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### src/pn3o_dpath.sv
// ----------------------------------------------------------------------------
// pn3o_dpath
// Datapath: permutation memory, coordinate scaling, fade pipeline, hash
// chain, gradients, shared lerp multiplier, weighted sum, restoring divider
// and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module pn3o_dpath #(
  parameter int unsigned MAX_OCTAVES = 8
) (
  input  wire logic                 clk_i,
  input  wire pn3o_pkg::ctrl_cmd_t  cmd_i,
  input  wire logic [15:0]          freq_i,
  input  wire logic [7:0]           table_index_i,
  input  wire logic [7:0]           table_value_i,
  input  wire logic signed [31:0]   coord_x_i,
  input  wire logic signed [31:0]   coord_y_i,
  input  wire logic signed [31:0]   coord_z_i,
  output logic signed [15:0]        noise_o
);

  localparam int unsigned TW = pn3o_pkg::VAL_W + MAX_OCTAVES;
  localparam int unsigned WW = MAX_OCTAVES + 2;
  localparam logic [MAX_OCTAVES-1:0] WGT_INIT = MAX_OCTAVES'(1) << (MAX_OCTAVES - 1);

  // Permutation memory
  logic [7:0] mem [pn3o_pkg::TABLE_DEPTH];
  logic [7:0] raddr;
  logic [7:0] rdata_q;

  // Per-axis state
  logic [31:0] coord    [3];
  logic [31:0] p_next   [3];
  logic [31:0] p_q      [3];
  logic [7:0]  cell_q   [3];
  logic [15:0] frac_q   [3];
  logic [31:0] tt_d     [3];
  logic [31:0] tt_q     [3];
  logic [31:0] t3p_d    [3];
  logic [31:0] t3p_q    [3];
  logic [35:0] six      [3];
  logic [20:0] q21      [3];
  logic [19:0] qv_q     [3];
  logic [35:0] f36      [3];
  logic [16:0] fade_q   [3];

  // Hash chain
  logic [7:0] a_q, b_q, aa_q, ab_q, ba_q, bb_q;

  // Corner values and lerp
  logic signed [pn3o_pkg::VAL_W-1:0] vals_q [8];
  logic signed [pn3o_pkg::GRAD_W-1:0] g_d;
  logic signed [17:0]                 gx, gy, gz;
  logic [pn3o_pkg::STEP_W-1:0]        lstep;
  logic [2:0]                         lj;
  logic [16:0]                        tsel;
  logic signed [pn3o_pkg::VAL_W-1:0]  va, vb;
  logic signed [20:0]                 diff;
  logic signed [38:0]                 prod_d;
  logic signed [38:0]                 prod_q;
  logic signed [pn3o_pkg::VAL_W-1:0]  alerp_q;

  // Accumulation and division
  logic signed [TW-1:0]      acc_add;
  logic signed [TW-1:0]      total_q;
  logic [MAX_OCTAVES-1:0]    wsum_q;
  logic [MAX_OCTAVES-1:0]    wgt_q;
  logic [TW-1:0]             dvd_q;
  logic                      neg_q;
  logic [WW-1:0]             rem_q;
  logic [WW-1:0]             divisor;
  logic [WW:0]               rem_sh;
  logic                      qbit;
  logic [WW-1:0]             rem_nx;
  logic                      pos_big, neg_big;
  logic [15:0]               sat;

  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;

  // Scaling and fade arithmetic per axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_next[k] = coord[k] * {16'd0, freq_i};
      tt_d[k]   = {16'd0, frac_q[k]} * {16'd0, frac_q[k]};
      t3p_d[k]  = {16'd0, tt_q[k][31:16]} * {16'd0, frac_q[k]};
      six[k]    = ({4'd0, tt_q[k]} << 2) + ({4'd0, tt_q[k]} << 1);
      q21[k]    = {2'd0, six[k][34:16]} + pn3o_pkg::FADE_TEN
                - ({5'd0, frac_q[k]} * pn3o_pkg::FADE_15);
      f36[k]    = {20'd0, t3p_q[k][31:16]} * {16'd0, qv_q[k]};
    end
  end

  // Read address schedule of the hash chain
  always_comb begin
    case (cmd_i.step)
      5'd1:    raddr = cell_q[0];
      5'd2:    raddr = cell_q[0] + 8'd1;
      5'd3:    raddr = a_q;
      5'd4:    raddr = a_q + 8'd1;
      5'd5:    raddr = b_q;
      5'd6:    raddr = b_q + 8'd1;
      5'd7:    raddr = aa_q;
      5'd8:    raddr = ba_q;
      5'd9:    raddr = ab_q;
      5'd10:   raddr = bb_q;
      5'd11:   raddr = aa_q + 8'd1;
      5'd12:   raddr = ba_q + 8'd1;
      5'd13:   raddr = ab_q + 8'd1;
      5'd14:   raddr = bb_q + 8'd1;
      default: raddr = cell_q[0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == pn3o_pkg::CMD_LOAD) begin
      mem[table_index_i] <= table_value_i;
    end
    rdata_q <= mem[raddr];
  end

  // Gradient for corner step-8: bit 0 picks x-1, bit 1 y-1, bit 2 z-1
  always_comb begin
    gx  = cmd_i.step[0] ? {2'b11, frac_q[0]} : {2'b00, frac_q[0]};
    gy  = cmd_i.step[1] ? {2'b11, frac_q[1]} : {2'b00, frac_q[1]};
    gz  = cmd_i.step[2] ? {2'b11, frac_q[2]} : {2'b00, frac_q[2]};
    g_d = pn3o_pkg::grad(rdata_q[3:0], gx, gy, gz);
  end

  // Shared lerp: even step multiplies, odd step adds back
  always_comb begin
    lstep = cmd_i.step - pn3o_pkg::STEP_LERP0;
    lj    = lstep[3:1];
    va    = vals_q[pn3o_pkg::lerp_a(lj)];
    vb    = vals_q[pn3o_pkg::lerp_b(lj)];
    if (lj < 3'd4) begin
      tsel = fade_q[0];
    end else if (lj < 3'd6) begin
      tsel = fade_q[1];
    end else begin
      tsel = fade_q[2];
    end
    diff    = {vb[pn3o_pkg::VAL_W-1], vb} - {va[pn3o_pkg::VAL_W-1], va};
    prod_d  = $signed({1'b0, tsel}) * diff;
    acc_add = vals_q[0] * $signed({1'b0, wgt_q});
  end

  // Restoring divider step and output saturation
  always_comb begin
    divisor = {wsum_q, 2'b00};
    rem_sh  = {rem_q, dvd_q[TW-1]};
    qbit    = (rem_sh >= {1'b0, divisor});
    rem_nx  = qbit ? WW'(rem_sh - {1'b0, divisor}) : rem_sh[WW-1:0];
    pos_big = |dvd_q[TW-1:15];
    neg_big = (|dvd_q[TW-1:16]) || (dvd_q[15] && (|dvd_q[14:0]));
    if (!neg_q) begin
      sat = pos_big ? pn3o_pkg::SAT_POS : dvd_q[15:0];
    end else begin
      sat = neg_big ? pn3o_pkg::SAT_NEG : 16'(-dvd_q[15:0]);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      pn3o_pkg::CMD_EVAL: begin
        for (int k = 0; k < 3; k++) begin
          p_q[k] <= p_next[k];
        end
        total_q <= '0;
        wsum_q  <= '0;
        wgt_q   <= WGT_INIT;
      end
      pn3o_pkg::CMD_ZERO: begin
        dvd_q <= '0;
        neg_q <= 1'b0;
      end
      pn3o_pkg::CMD_STEP: begin
        if (cmd_i.step == pn3o_pkg::STEP_SPLIT) begin
          for (int k = 0; k < 3; k++) begin
            cell_q[k] <= p_q[k][31:24];
            frac_q[k] <= p_q[k][23:8];
          end
        end
        if (cmd_i.step == pn3o_pkg::STEP_SQR) begin
          for (int k = 0; k < 3; k++) begin
            tt_q[k] <= tt_d[k];
          end
        end
        if (cmd_i.step == pn3o_pkg::STEP_CUBE) begin
          for (int k = 0; k < 3; k++) begin
            t3p_q[k] <= t3p_d[k];
            qv_q[k]  <= q21[k][19:0];
          end
        end
        if (cmd_i.step == pn3o_pkg::STEP_FADE) begin
          for (int k = 0; k < 3; k++) begin
            fade_q[k] <= f36[k][32:16];
          end
        end
        // Hash chain captures
        case (cmd_i.step)
          5'd2:    a_q  <= rdata_q + cell_q[1];
          5'd3:    b_q  <= rdata_q + cell_q[1];
          5'd4:    aa_q <= rdata_q + cell_q[2];
          5'd5:    ab_q <= rdata_q + cell_q[2];
          5'd6:    ba_q <= rdata_q + cell_q[2];
          5'd7:    bb_q <= rdata_q + cell_q[2];
          default: ;
        endcase
        if ((cmd_i.step >= pn3o_pkg::STEP_GRAD0) && (cmd_i.step < pn3o_pkg::STEP_LERP0)) begin
          vals_q[cmd_i.step[2:0]] <= pn3o_pkg::VAL_W'(g_d);
        end
        if ((cmd_i.step >= pn3o_pkg::STEP_LERP0) && (cmd_i.step < pn3o_pkg::STEP_LAST)) begin
          if (!lstep[0]) begin
            prod_q  <= prod_d;
            alerp_q <= va;
          end else begin
            vals_q[pn3o_pkg::lerp_a(lj)] <= alerp_q + prod_q[35:16];
          end
        end
        // Weighted accumulate, next octave doubles the frequency
        if (cmd_i.step == pn3o_pkg::STEP_LAST) begin
          total_q <= total_q + acc_add;
          wsum_q  <= wsum_q + wgt_q;
          wgt_q   <= wgt_q >> 1;
          for (int k = 0; k < 3; k++) begin
            p_q[k] <= p_q[k] << 1;
          end
        end
      end
      pn3o_pkg::CMD_DIV_INIT: begin
        neg_q <= total_q[TW-1];
        dvd_q <= total_q[TW-1] ? TW'(-total_q) : TW'(total_q);
        rem_q <= '0;
      end
      pn3o_pkg::CMD_DIV: begin
        rem_q <= rem_nx;
        dvd_q <= {dvd_q[TW-2:0], qbit};
      end
      pn3o_pkg::CMD_OUT: begin
        noise_o <= sat;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### src/perlin_noise_3d_octaves.sv
// ----------------------------------------------------------------------------
// perlin_noise_3d_octaves
// Improved 3D gradient noise summed over octaves, fixed point.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): a request with op_i = 0 writes one
// permutation entry and gives no result; op_i = 1 evaluates the point
// coord_x_i/y_i/z_i (signed Q16.16). Output channel (out_valid_o /
// out_stall_i) carries noise_value_o in signed Q2.14, saturated.
// A load leaves the block idle. The time of an evaluate is set by the single
// read port of the permutation memory (14 dependent reads per octave) and the
// one shared lerp multiplier (7 lerps per octave, each a multiply step and an
// add step); the final normalization runs a restoring divider at one quotient
// bit per cycle. One request is worked on at a time. The result waits in an
// output register, so loads and the next evaluate are taken while the
// receiver stalls; a finished result waits until that register is free.
// Reset empties the output and restores the registers (frequency 1.0, one
// octave, amplitude 1.0); the permutation table is undefined until software
// loads it. Configuration writes go through cfg_we_i / cfg_index_i /
// cfg_data_i; the user must make them only while the block is idle, as the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module perlin_noise_3d_octaves #(
  parameter int unsigned MAX_OCTAVES = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [7:0]         table_index_i,
  input  wire logic [7:0]         table_value_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      noise_value_o
);

  logic [15:0]         freq_q;
  logic [3:0]          octcnt_q;
  logic [15:0]         amp_q;
  pn3o_pkg::ctrl_cmd_t cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q   <= 16'd256;
      octcnt_q <= 4'd1;
      amp_q    <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pn3o_pkg::CFG_FREQ: freq_q   <= cfg_data_i;
        pn3o_pkg::CFG_OCT:  octcnt_q <= cfg_data_i[3:0];
        pn3o_pkg::CFG_AMP:  amp_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pn3o_ctrl #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .octave_count_i (octcnt_q),
    .amp_zero_i     (amp_q == 16'd0),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cmd_o          (cmd)
  );

  pn3o_dpath #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_dpath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .freq_i        (freq_q),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .noise_o       (noise_value_o)
  );

endmodule

`default_nettype wire

### src/pn3o_chk.sv
// ----------------------------------------------------------------------------
// pn3o_chk
// Port-level checks for the octave noise block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pn3o_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        op_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] noise_value_o
);

  // Output register is empty during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(noise_value_o))
    else $error("stalled result changed");

  // An evaluate request keeps the block busy afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i |=> in_stall_o)
    else $error("evaluate did not occupy the block");

  // A table load completes in its accept cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !op_i |=> !in_stall_o)
    else $error("table load blocked the input");

endmodule

bind perlin_noise_3d_octaves pn3o_chk u_pn3o_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .op_i          (op_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .noise_value_o (noise_value_o)
);

`default_nettype wire
